[src/bad_pkg.sv]
package bad_pkg;

  // response status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ADDR_ERR = 2'd1;
  localparam logic [1:0] ST_BUS_ERR  = 2'd2;

  // target select codes
  localparam logic [2:0] TG_NONE  = 3'd0;
  localparam logic [2:0] TG_CART  = 3'd1;
  localparam logic [2:0] TG_SOUND = 3'd2;
  localparam logic [2:0] TG_IO    = 3'd3;
  localparam logic [2:0] TG_CTRL  = 3'd4;
  localparam logic [2:0] TG_VIDEO = 3'd5;
  localparam logic [2:0] TG_WRAM  = 3'd6;

  // bus geometry
  localparam int ADDR_W  = 24;
  localparam int DATA_W  = 32;
  localparam int WRAM_AW = 16;

  // region bounds
  localparam logic [7:0]  TOP_CART_END = 8'h40;
  localparam logic [7:0]  TOP_SOUND    = 8'hA0;
  localparam logic [7:0]  TOP_IOCTRL   = 8'hA1;
  localparam logic [7:0]  TOP_VIDEO    = 8'hC0;
  localparam logic [7:0]  TOP_WRAM     = 8'hFF;
  localparam logic [24:0] CART_LIMIT   = 25'h0400000;
  localparam logic [23:0] IO_END       = 24'hA10020;
  localparam logic [23:0] CTRL_BEGIN   = 24'hA11000;
  localparam logic [23:0] CTRL_END     = 24'hA11202;
  localparam logic [24:0] WRAM_LIMIT   = 25'h1000000;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] target;
  } dec_t;

endpackage

[src/bus_address_decoder_with_work_ram.sv]
// channel  | direction | valid / stall          | words
// ---------+-----------+------------------------+----------------------------------------
// request  | in        | req_valid / req_stall  | kind, address, size, write_data
// response | out       | rsp_valid / rsp_stall  | status, target, target_address, read_data
//
// after reset the work ram is cleared one byte a cycle, with req_stall held high
// non-ram accesses and errors load the response register when it is free; work ram accesses
// take the index modulo through one multiplier, pass one byte a cycle through the single ram
// port, take in the last read byte, load the response register and then hand it out
// a finished word waits in the response register while the next request is taken;
// one more decoded result can wait behind it before req_stall rises
module bus_address_decoder_with_work_ram #(
  parameter int RAM_BYTES = 65536
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic                       kind,
  input  logic [bad_pkg::ADDR_W-1:0] address,
  input  logic [2:0]                 size,
  input  logic [bad_pkg::DATA_W-1:0] write_data,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic [1:0]                 status,
  output logic [2:0]                 target,
  output logic [bad_pkg::ADDR_W-1:0] target_address,
  output logic [bad_pkg::DATA_W-1:0] read_data
);
  import bad_pkg::*;

  // ram index width and the reciprocal used to take the 16-bit offset modulo RAM_BYTES
  localparam int IDX_W    = $clog2(RAM_BYTES);
  localparam int RECIP_W  = 33 - IDX_W;
  localparam int PROD_W   = WRAM_AW + RECIP_W;
  localparam int Q_W      = PROD_W - 32;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 32) / RAM_BYTES);
  localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(RAM_BYTES - 1);
  localparam logic [WRAM_AW:0]   N_EXT    = (WRAM_AW + 1)'(RAM_BYTES);

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD1  = 3'd2;
  localparam logic [2:0] S_MOD2  = 3'd3;
  localparam logic [2:0] S_XFER  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  // work ram, one byte per entry, synchronous read
  logic [7:0]       mem [RAM_BYTES];
  logic [IDX_W-1:0] mem_addr;
  logic             mem_we;
  logic [7:0]       mem_wd;
  logic [7:0]       mem_q;

  logic [IDX_W-1:0] clr;

  dec_t dec;
  logic accept;
  logic out_free;

  // pending result and working registers
  logic [1:0]         res_status;
  logic [2:0]         res_target;
  logic [ADDR_W-1:0]  res_taddr;
  logic               is_wr;
  logic [1:0]         cnt;
  logic [WRAM_AW-1:0] a16;
  logic [IDX_W-1:0]   idx;
  logic [DATA_W-1:0]  wbuf;
  logic [DATA_W-1:0]  rbuf;
  logic               rd_vld;
  logic [PROD_W-1:0]  prod;

  logic [Q_W-1:0]     quo;
  logic [WRAM_AW:0]   rem;

  bad_decode u_dec (
    .kind    (kind),
    .address (address),
    .size    (size),
    .dec     (dec)
  );

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // remainder after the estimated quotient; lands below twice the ram size
  assign quo = prod[PROD_W-1:32];
  assign rem = {1'b0, a16} - (WRAM_AW + 1)'((WRAM_AW + 1)'(quo) * N_EXT);

  always_comb begin
    mem_addr = idx;
    mem_we   = 1'b0;
    mem_wd   = wbuf[DATA_W-1 -: 8];
    unique case (state)
      S_CLEAR: begin
        mem_addr = clr;
        mem_we   = 1'b1;
        mem_wd   = 8'h00;
      end
      S_XFER: begin
        mem_we = is_wr;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    mem_q <= mem[mem_addr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr == IDX_LAST) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (dec.target == TG_WRAM) state_next = S_MOD1;
          else if (!out_free) state_next = S_DONE;
        end
      end
      S_MOD1: state_next = S_MOD2;
      S_MOD2: state_next = S_XFER;
      S_XFER: if (cnt == 2'd0) state_next = S_FIN;
      S_FIN:  state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr <= clr + IDX_W'(1);
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    rd_vld <= (state == S_XFER) && !is_wr;
    if (accept) begin
      res_status <= dec.status;
      res_target <= dec.target;
      res_taddr  <= (dec.status == ST_OK) ? address : '0;
      is_wr      <= kind;
      cnt        <= 2'(size - 3'd1);
      a16        <= address[WRAM_AW-1:0];
      rbuf       <= '0;
      unique case (size)
        3'd1:    wbuf <= write_data << 24;
        3'd2:    wbuf <= write_data << 16;
        default: wbuf <= write_data;
      endcase
    end else if (rd_vld) begin
      // read bytes arrive lowest address first, shifted in at the least significant end
      rbuf <= {rbuf[DATA_W-9:0], mem_q};
    end
    if (state == S_MOD1) prod <= PROD_W'(a16) * PROD_W'(RECIP);
    if (state == S_MOD2) idx <= (rem >= N_EXT) ? IDX_W'(rem - N_EXT) : IDX_W'(rem);
    if (state == S_XFER) begin
      wbuf <= wbuf << 8;
      cnt  <= cnt - 2'd1;
      a16  <= a16 + WRAM_AW'(1);
      // offset wraps at 64 KiB, index wraps at the ram size
      if (a16 == '1 || idx == IDX_LAST) idx <= '0;
      else idx <= idx + IDX_W'(1);
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_IDLE && accept && dec.target != TG_WRAM && out_free) ||
                 (state == S_DONE && out_free)) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && dec.target != TG_WRAM && out_free) begin
      status         <= dec.status;
      target         <= dec.target;
      target_address <= (dec.status == ST_OK) ? address : '0;
      read_data      <= '0;
    end else if (state == S_DONE && out_free) begin
      status         <= res_status;
      target         <= res_target;
      target_address <= res_taddr;
      read_data      <= rbuf;
    end
  end

endmodule

[src/bad_decode.sv]
module bad_decode (
  input  logic                  kind,
  input  logic [bad_pkg::ADDR_W-1:0] address,
  input  logic [2:0]            size,
  output bad_pkg::dec_t         dec
);
  import bad_pkg::*;

  logic [7:0]  top;
  logic [24:0] last_plus;
  logic        size_ok;
  logic [2:0]  tgt;

  assign top       = address[23:16];
  assign last_plus = {1'b0, address} + 25'(size);
  assign size_ok   = (size == 3'd1) || (size == 3'd2) || (size == 3'd4);

  always_comb begin
    tgt = TG_NONE;
    priority if (top < TOP_CART_END) begin
      if (!kind && last_plus <= CART_LIMIT) tgt = TG_CART;
    end else if (top == TOP_SOUND) begin
      tgt = TG_SOUND;
    end else if (top == TOP_IOCTRL) begin
      if (address < IO_END) tgt = TG_IO;
      else if (address >= CTRL_BEGIN && address < CTRL_END) tgt = TG_CTRL;
    end else if (top == TOP_VIDEO) begin
      tgt = TG_VIDEO;
    end else if (top == TOP_WRAM) begin
      if (last_plus <= WRAM_LIMIT) tgt = TG_WRAM;
    end else begin
      tgt = TG_NONE;
    end
  end

  always_comb begin
    priority if (!size_ok) begin
      dec.status = ST_BUS_ERR;
      dec.target = TG_NONE;
    end else if (size != 3'd1 && address[0]) begin
      dec.status = ST_ADDR_ERR;
      dec.target = TG_NONE;
    end else if (tgt == TG_NONE) begin
      dec.status = ST_BUS_ERR;
      dec.target = TG_NONE;
    end else begin
      dec.status = ST_OK;
      dec.target = tgt;
    end
  end

endmodule
